/* hw/rtl/cgpc_pkg.sv */
// Shared types and constants for the corner-gradient pixel color pipeline.
// Used by cgpc_div and corner_gradient_pixel_color_top. No other dependencies.
package cgpc_pkg;

	// Fixed field widths of the block's ports.
	localparam int COORD_W = 10;
	localparam int DIM_W   = 11;
	localparam int CH_W    = 8;
	localparam int COLOR_W = 3 * CH_W;
	localparam int CFG_IDX_W = 2;

	// Fractional bits of a distance: sqrt(d^2 * 2^(2*DIST_FRAC)).
	localparam int DIST_FRAC = 8;

	// Blend weight in Q12, range 0..4096, so one extra bit.
	localparam int W_SHIFT = 12;
	localparam int WGT_W   = W_SHIFT + 1;
	localparam logic [WGT_W-1:0] W_ONE  = WGT_W'(1) << W_SHIFT;
	localparam logic [WGT_W-1:0] W_HALF = WGT_W'(1) << (W_SHIFT - 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_START  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_END    = 2'd3;

	// Register values after reset.
	localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 11'd10;
	localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 11'd10;
	localparam logic [COLOR_W-1:0] RST_COLOR_START  = 24'hFF00FF;
	localparam logic [COLOR_W-1:0] RST_COLOR_END    = 24'h00FF00;

	typedef logic [CH_W-1:0] channel_t;

endpackage

/* hw/rtl/cgpc_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Stand-alone module; the enclosing pipeline supplies the advance enable.
module cgpc_isqrt #(
	parameter int IN_W = 37
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [IN_W-1:0]         value,
	output logic [(IN_W+1)/2-1:0]   root
);

	localparam int RT_W = (IN_W + 1) / 2;
	localparam int AC_W = IN_W + 1;

	logic [IN_W-1:0] rem_s [RT_W];
	logic [AC_W-1:0] res_s [RT_W];

	genvar k;
	generate
		for (k = 0; k < RT_W; k++) begin : g_step
			// Each stage tests one power of four, largest first.
			localparam logic [AC_W-1:0] BIT = AC_W'(1) << (2 * (RT_W - 1 - k));
			logic [IN_W-1:0] rem_in;
			logic [AC_W-1:0] res_in;
			logic [AC_W-1:0] trial;

			if (k == 0) begin : g_first
				assign rem_in = value;
				assign res_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign res_in = res_s[k-1];
			end

			assign trial = res_in + BIT;

			always_ff @(posedge clk) begin
				if (en) begin
					if (AC_W'(rem_in) >= trial) begin
						rem_s[k] <= rem_in - IN_W'(trial);
						res_s[k] <= (res_in >> 1) + BIT;
					end else begin
						rem_s[k] <= rem_in;
						res_s[k] <= res_in >> 1;
					end
				end
			end
		end
	endgenerate

	assign root = res_s[RT_W-1][RT_W-1:0];

endmodule

/* hw/rtl/cgpc_div.sv */
// Pipelined restoring divider that forms the Q12 blend weight num*4096/den.
// Depends on cgpc_pkg for the weight width; expects num <= den.
module cgpc_div #(
	parameter int N_W = 20
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [N_W-1:0]             num,
	input  logic [N_W-1:0]             den,
	output logic [cgpc_pkg::WGT_W-1:0] weight
);

	localparam int Q_W = cgpc_pkg::WGT_W;

	logic [N_W-1:0] rem_s  [Q_W];
	logic [N_W-1:0] den_s  [Q_W];
	logic [Q_W-1:0] quo_s  [Q_W];
	logic           zero_s [Q_W];

	genvar k;
	generate
		for (k = 0; k < Q_W; k++) begin : g_step
			logic [N_W:0]   rem_sh;
			logic [N_W-1:0] den_in;
			logic [Q_W-1:0] quo_in;
			logic           zero_in;
			logic           take;

			// The first stage decides the integer bit; later stages shift in zeros.
			if (k == 0) begin : g_first
				assign rem_sh  = {1'b0, num};
				assign den_in  = den;
				assign quo_in  = '0;
				assign zero_in = (den == '0);
			end else begin : g_next
				assign rem_sh  = {rem_s[k-1], 1'b0};
				assign den_in  = den_s[k-1];
				assign quo_in  = quo_s[k-1];
				assign zero_in = zero_s[k-1];
			end

			assign take = (rem_sh >= {1'b0, den_in});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= take ? N_W'(rem_sh - {1'b0, den_in}) : rem_sh[N_W-1:0];
					den_s[k]  <= den_in;
					quo_s[k]  <= {quo_in[Q_W-2:0], take};
					zero_s[k] <= zero_in;
				end
			end
		end
	endgenerate

	// Both distances zero only on a one-pixel frame: mix the colors equally.
	assign weight = zero_s[Q_W-1] ? cgpc_pkg::W_HALF : quo_s[Q_W-1];

endmodule

/* hw/rtl/corner_gradient_pixel_color_top.sv */
// Throughput: one pixel per cycle; the whole pipeline holds while an output waits.
// The depth is set by the two bit-per-stage square roots and the 13-stage divider.
// Reset clears the valid pipeline and loads the default frame size and colors.
// Top level of the corner-gradient pixel color pipeline.
// Depends on cgpc_pkg, cgpc_isqrt and cgpc_div.
module corner_gradient_pixel_color_top #(
	parameter int MAX_SIDE = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic [cgpc_pkg::COORD_W-1:0]      row,
	input  logic [cgpc_pkg::COORD_W-1:0]      column,
	output logic                              rgb_valid,
	input  logic                              rgb_stall,
	output cgpc_pkg::channel_t                red,
	output cgpc_pkg::channel_t                green,
	output cgpc_pkg::channel_t                blue,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cgpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cgpc_pkg::COLOR_W-1:0]      cfg_data
);

	localparam int SIDE_W = $clog2(MAX_SIDE);
	localparam int DW     = (cgpc_pkg::COORD_W > SIDE_W) ? cgpc_pkg::COORD_W : SIDE_W;
	localparam int LIM_W  = (cgpc_pkg::DIM_W > SIDE_W + 1) ? cgpc_pkg::DIM_W : SIDE_W + 1;
	localparam int SQ_W   = 2 * DW + 1;
	localparam int V_W    = SQ_W + 2 * cgpc_pkg::DIST_FRAC;
	localparam int RT_W   = (V_W + 1) / 2;
	localparam int SUM_W  = RT_W + 1;
	localparam int WGT_W  = cgpc_pkg::WGT_W;
	localparam int CH_W   = cgpc_pkg::CH_W;
	localparam int PR_W   = CH_W + WGT_W;
	localparam int LAT    = 3 + RT_W + 1 + WGT_W + 2;

	// Configuration registers.
	logic [cgpc_pkg::DIM_W-1:0]   frame_width_q;
	logic [cgpc_pkg::DIM_W-1:0]   frame_height_q;
	logic [cgpc_pkg::COLOR_W-1:0] color_start_q;
	logic [cgpc_pkg::COLOR_W-1:0] color_end_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= cgpc_pkg::RST_FRAME_WIDTH;
			frame_height_q <= cgpc_pkg::RST_FRAME_HEIGHT;
			color_start_q  <= cgpc_pkg::RST_COLOR_START;
			color_end_q    <= cgpc_pkg::RST_COLOR_END;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cgpc_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[cgpc_pkg::DIM_W-1:0];
				cgpc_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[cgpc_pkg::DIM_W-1:0];
				cgpc_pkg::CFG_COLOR_START:  color_start_q  <= cfg_data;
				cgpc_pkg::CFG_COLOR_END:    color_end_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a finished result is held back.
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !(rgb_valid && rgb_stall);
	assign pix_stall = !en;
	assign rgb_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pix_valid};
		end
	end

	// Index of the last row and column, with the frame size limited to 1..MAX_SIDE.
	function automatic logic [SIDE_W-1:0] last_index(input logic [cgpc_pkg::DIM_W-1:0] dim);
		logic [LIM_W-1:0] ext;
		ext = LIM_W'(dim);
		if (ext == '0) begin
			return '0;
		end else if (ext > LIM_W'(MAX_SIDE)) begin
			return SIDE_W'(MAX_SIDE - 1);
		end else begin
			return SIDE_W'(ext - LIM_W'(1));
		end
	endfunction

	function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a, input logic [DW-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	logic [DW-1:0] last_row;
	logic [DW-1:0] last_col;

	assign last_row = DW'(last_index(frame_height_q));
	assign last_col = DW'(last_index(frame_width_q));

	// Stage 1: coordinates and their offsets from the far corner.
	logic [DW-1:0] row_s1, col_s1, drow_s1, dcol_s1;
	// Stage 2: squares.
	logic [2*DW-1:0] row2_s2, col2_s2, drow2_s2, dcol2_s2;
	// Stage 3: squared distances.
	logic [SQ_W-1:0] sq0_s3, sq1_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1   <= DW'(row);
			col_s1   <= DW'(column);
			drow_s1  <= abs_diff(DW'(row), last_row);
			dcol_s1  <= abs_diff(DW'(column), last_col);
			row2_s2  <= (2 * DW)'(row_s1) * (2 * DW)'(row_s1);
			col2_s2  <= (2 * DW)'(col_s1) * (2 * DW)'(col_s1);
			drow2_s2 <= (2 * DW)'(drow_s1) * (2 * DW)'(drow_s1);
			dcol2_s2 <= (2 * DW)'(dcol_s1) * (2 * DW)'(dcol_s1);
			sq0_s3   <= SQ_W'(row2_s2) + SQ_W'(col2_s2);
			sq1_s3   <= SQ_W'(drow2_s2) + SQ_W'(dcol2_s2);
		end
	end

	// Distances with eight fractional bits.
	logic [RT_W-1:0] d0, d1;

	cgpc_isqrt #(.IN_W(V_W)) u_sqrt_near (
		.clk   (clk),
		.en    (en),
		.value ({sq0_s3, (2 * cgpc_pkg::DIST_FRAC)'(0)}),
		.root  (d0)
	);

	cgpc_isqrt #(.IN_W(V_W)) u_sqrt_far (
		.clk   (clk),
		.en    (en),
		.value ({sq1_s3, (2 * cgpc_pkg::DIST_FRAC)'(0)}),
		.root  (d1)
	);

	// Stage 4: distance sum feeds the divider.
	logic [SUM_W-1:0] d0_s4, sum_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			d0_s4  <= SUM_W'(d0);
			sum_s4 <= SUM_W'(d0) + SUM_W'(d1);
		end
	end

	logic [WGT_W-1:0] w1;

	cgpc_div #(.N_W(SUM_W)) u_div (
		.clk    (clk),
		.en     (en),
		.num    (d0_s4),
		.den    (sum_s4),
		.weight (w1)
	);

	// Stage 5: per-channel products; stage 6: rounded blend.
	logic [PR_W-1:0]  ps_s5 [3];
	logic [PR_W-1:0]  pe_s5 [3];
	logic [WGT_W-1:0] w0;
	cgpc_pkg::channel_t ch_s6 [3];

	assign w0 = cgpc_pkg::W_ONE - w1;

	genvar c;
	generate
		for (c = 0; c < 3; c++) begin : g_chan
			localparam int SH = (2 - c) * CH_W;
			logic [PR_W:0] mix;

			assign mix = (PR_W + 1)'(ps_s5[c]) + (PR_W + 1)'(pe_s5[c])
				+ (PR_W + 1)'(cgpc_pkg::W_HALF);

			always_ff @(posedge clk) begin
				if (en) begin
					ps_s5[c] <= PR_W'(color_start_q[SH +: CH_W]) * PR_W'(w0);
					pe_s5[c] <= PR_W'(color_end_q[SH +: CH_W]) * PR_W'(w1);
					ch_s6[c] <= mix[cgpc_pkg::W_SHIFT +: CH_W];
				end
			end
		end
	endgenerate

	assign red   = ch_s6[0];
	assign green = ch_s6[1];
	assign blue  = ch_s6[2];

	// The input is held back only while a finished result waits.
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (rgb_valid && rgb_stall))
		else $error("input stalled without a waiting result");

	// A held pipeline keeps every valid bit where it was.
	a_hold_keeps_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during a hold");

	// The blend weight of a live item never exceeds one.
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-3] |-> (w1 <= cgpc_pkg::W_ONE))
		else $error("blend weight out of range");

	// The near distance never exceeds the distance sum.
	a_num_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3 + RT_W] |-> (d0_s4 <= sum_s4))
		else $error("divider numerator above denominator");

endmodule
